FILE: rtl/cseb_pkg.sv
// ----------------------------------------------------------------------------
// cseb_pkg
// Types and constants shared by the strip energy binner.
// ----------------------------------------------------------------------------
`default_nettype none

package cseb_pkg;

  // field widths
  localparam int unsigned ETA_W    = 16;
  localparam int unsigned PHI_W    = 15;
  localparam int unsigned EN_W     = 24;
  localparam int unsigned SIG_W    = 23;
  localparam int unsigned STRIP_W  = 6;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned NUM_W    = 7;
  localparam int unsigned INV_W    = 16;
  localparam int unsigned SCALE_W  = 17;
  localparam int unsigned FACT_W   = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // internal widths
  localparam int unsigned OFS_W   = 17;  // centre minus cell offset
  localparam int unsigned PROD_W  = 35;  // offset times reciprocal width
  localparam int unsigned IDX_W   = 15;  // rounded index
  localparam int unsigned ADD_W   = 41;  // energy times scale
  localparam int unsigned NPROD_W = 35;  // factor times sigma
  localparam int unsigned NCMP_W  = 37;  // noise cut comparison
  localparam int unsigned POS_W   = 18;  // signed strip position

  localparam logic signed [OFS_W-1:0] PI_Q12     = 17'sd12868;
  localparam logic signed [OFS_W-1:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic [PROD_W-1:0]       ROUND_HALF = 35'd524288;
  localparam int unsigned             ROUND_SH   = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SELECT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_STRIPS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STRIP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ETA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_PHI       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_SCALE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_CUT_ENABLE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_CUT_FACTOR = 3'd7;

  typedef struct packed {
    logic                       axis_select;
    logic [NUM_W-1:0]           num_strips;
    logic [INV_W-1:0]           inv_strip_width;
    logic signed [ETA_W-1:0]    center_eta;
    logic signed [PHI_W-1:0]    center_phi;
    logic [SCALE_W-1:0]         energy_scale;
    logic                       noise_cut_enable;
    logic [FACT_W-1:0]          noise_cut_factor;
  } cseb_cfg_t;

  // binning result handed to the cell row
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               last;
    logic [STRIP_W-1:0] strip;
  } cseb_bin_t;

  // per-cell control
  typedef struct packed {
    logic hit;
    logic shift;
  } cseb_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/cseb_if.sv
// ----------------------------------------------------------------------------
// cseb interfaces
// Valid/ready channels for cells, strip sums and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cseb_cell_if import cseb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ETA_W-1:0] cell_eta;
  logic signed [PHI_W-1:0] cell_phi;
  logic signed [EN_W-1:0]  cell_energy;
  logic [SIG_W-1:0]        cell_sigma;
  logic                    cell_valid;
  logic                    last_cell;

  modport source (output valid, cell_eta, cell_phi, cell_energy, cell_sigma,
                  cell_valid, last_cell, input ready);
  modport sink   (input valid, cell_eta, cell_phi, cell_energy, cell_sigma,
                  cell_valid, last_cell, output ready);
endinterface

interface cseb_strip_if import cseb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STRIP_W-1:0]      strip_index;
  logic signed [SUM_W-1:0] strip_sum;
  logic                    last_strip;

  modport source (output valid, strip_index, strip_sum, last_strip, input ready);
  modport sink   (input valid, strip_index, strip_sum, last_strip, output ready);
endinterface

interface cseb_cfg_if import cseb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cseb_front.sv
// ----------------------------------------------------------------------------
// cseb_front
// Three-stage binning pipe: offset, rounding, strip number and scaled energy.
// ----------------------------------------------------------------------------
`default_nettype none

module cseb_front import cseb_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [ETA_W-1:0] cell_eta_i,
  input  wire logic signed [PHI_W-1:0] cell_phi_i,
  input  wire logic signed [EN_W-1:0]  cell_energy_i,
  input  wire logic [SIG_W-1:0]        cell_sigma_i,
  input  wire logic                    cell_valid_i,
  input  wire logic                    last_cell_i,
  input  wire cseb_cfg_t               cfg_i,
  input  wire logic [NUM_W-1:0]        n_eff_i,
  output cseb_bin_t                    bin_o,
  output logic [ADD_W-1:0]             addend_o
);

  // stage 1: offsets and products
  logic                    v1_q;
  logic signed [OFS_W-1:0] d1_q, d1_d;
  logic                    pos1_q, pos1_d;
  logic [ADD_W-1:0]        esc1_q, esc1_d;
  logic signed [EN_W-1:0]  en1_q;
  logic [NPROD_W-1:0]      np1_q, np1_d;
  logic                    keep1_q, last1_q;

  // stage 2: rounded index and noise cut
  logic                    v2_q;
  logic [IDX_W-1:0]        idx2_q, idx2_d;
  logic                    pos2_q;
  logic [ADD_W-1:0]        esc2_q;
  logic                    keep2_q, keep2_d;
  logic                    last2_q;

  // stage 3: strip number
  cseb_bin_t               bin_d;
  logic                    v3_q;
  logic                    hit3_q, last3_q;
  logic [STRIP_W-1:0]      strip3_q;
  logic [ADD_W-1:0]        add_q;

  logic signed [OFS_W-1:0] dphi_raw, dphi, deta;
  logic [PROD_W-1:0]       prod;
  logic signed [NCMP_W-1:0] ncmp_l, ncmp_r;
  logic signed [POS_W-1:0] spos;
  logic [NUM_W-1:0]        half;

  always_comb begin
    dphi_raw = {{2{cfg_i.center_phi[PHI_W-1]}}, cfg_i.center_phi}
             - {{2{cell_phi_i[PHI_W-1]}}, cell_phi_i};
    // wrap once into [-pi, pi)
    if (dphi_raw < -PI_Q12) begin
      dphi = dphi_raw + TWO_PI_Q12;
    end else if (dphi_raw >= PI_Q12) begin
      dphi = dphi_raw - TWO_PI_Q12;
    end else begin
      dphi = dphi_raw;
    end
    deta   = {cfg_i.center_eta[ETA_W-1], cfg_i.center_eta}
           - {cell_eta_i[ETA_W-1], cell_eta_i};
    d1_d   = cfg_i.axis_select ? dphi : deta;
    pos1_d = !dphi[OFS_W-1] && (dphi != '0);
    // 24 x 18 signed product
    esc1_d = ADD_W'(cell_energy_i * $signed({1'b0, cfg_i.energy_scale}));
    np1_d  = NPROD_W'(cfg_i.noise_cut_factor * cell_sigma_i);
  end

  always_comb begin
    // 17 x 17 signed product, then half a step for rounding up
    prod    = PROD_W'(d1_q * $signed({1'b0, cfg_i.inv_strip_width})) + ROUND_HALF;
    idx2_d  = prod[PROD_W-1:ROUND_SH];
    ncmp_l  = {{(NCMP_W-EN_W-8){en1_q[EN_W-1]}}, en1_q, 8'b0};
    ncmp_r  = {{(NCMP_W-NPROD_W){1'b0}}, np1_q};
    keep2_d = keep1_q && !(cfg_i.noise_cut_enable && (ncmp_l <= ncmp_r));
  end

  always_comb begin
    half = n_eff_i >> 1;
    spos = {{(POS_W-NUM_W){1'b0}}, half}
         - {{2{idx2_q[IDX_W-1]}}, idx2_q, 1'b0}
         - {{(POS_W-1){1'b0}}, pos2_q};
    bin_d.valid = v2_q;
    bin_d.last  = last2_q;
    // a negative position clamps to strip 0, which always exists
    if (spos[POS_W-1]) begin
      bin_d.strip = '0;
      bin_d.hit   = keep2_q;
    end else begin
      bin_d.strip = spos[STRIP_W-1:0];
      bin_d.hit   = keep2_q && (spos < {{(POS_W-NUM_W){1'b0}}, n_eff_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= bin_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q    <= d1_d;
    pos1_q  <= pos1_d;
    esc1_q  <= esc1_d;
    en1_q   <= cell_energy_i;
    np1_q   <= np1_d;
    keep1_q <= cell_valid_i;
    last1_q <= last_cell_i;

    idx2_q  <= idx2_d;
    pos2_q  <= pos1_q;
    esc2_q  <= esc1_q;
    keep2_q <= keep2_d;
    last2_q <= last1_q;

    hit3_q   <= bin_d.hit;
    last3_q  <= bin_d.last;
    strip3_q <= bin_d.strip;
    add_q    <= esc2_q;
  end

  assign bin_o    = '{valid: v3_q, hit: hit3_q, last: last3_q, strip: strip3_q};
  assign addend_o = add_q;

endmodule

`default_nettype wire

FILE: rtl/cseb_cell.sv
// ----------------------------------------------------------------------------
// cseb_cell
// One strip sum: saturating accumulate, or take the neighbour's sum on readout.
// ----------------------------------------------------------------------------
`default_nettype none

module cseb_cell import cseb_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cseb_cell_ctrl_t         ctrl_i,
  input  wire logic [ADD_W-1:0]        addend_i,
  input  wire logic signed [SUM_W-1:0] shift_i,
  output logic signed [SUM_W-1:0]      sum_o
);

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W:0]          acc;

  always_comb begin
    acc = {sum_q[SUM_W-1], sum_q}
        + {{(SUM_W+1-ADD_W){addend_i[ADD_W-1]}}, addend_i};
    sum_d = sum_q;
    priority if (ctrl_i.shift) begin
      sum_d = shift_i;
    end else if (ctrl_i.hit) begin
      // saturate when the two top bits differ
      if (acc[SUM_W] != acc[SUM_W-1]) begin
        sum_d = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_d = acc[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

FILE: rtl/calorimeter_strip_energy_binner.sv
// ----------------------------------------------------------------------------
// calorimeter_strip_energy_binner
// Bins scaled cell energy into strips around a centre; reads out on last cell.
// ----------------------------------------------------------------------------
// A cell word is taken only while idle and is then binned through the offset,
// rounding multiply and strip stages of the front pipe before the next is taken.
// After the last cell the strips in use leave, one a cycle while strip_o is ready,
// from the head of the cell row, which shifts to strip 0; the last word clears it.
// Reset clears all strip sums, the control state and sets register defaults.
`default_nettype none

module calorimeter_strip_energy_binner import cseb_pkg::*; #(
  parameter int unsigned MAX_STRIPS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cseb_cfg_if.sink    cfg_i,
  cseb_cell_if.sink   cell_i,
  cseb_strip_if.source strip_o
);

  localparam int unsigned CNT_W = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  cseb_cfg_t         cfg_q;
  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0]  n_eff;
  logic              accept, out_take, last_out;
  cseb_bin_t         bin;
  logic [ADD_W-1:0]  addend;

  logic signed [SUM_W-1:0] sums [MAX_STRIPS];
  cseb_cell_ctrl_t         ctrl [MAX_STRIPS];

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_select      <= 1'b0;
      cfg_q.num_strips       <= 7'd64;
      cfg_q.inv_strip_width  <= 16'd10240;
      cfg_q.center_eta       <= '0;
      cfg_q.center_phi       <= '0;
      cfg_q.energy_scale     <= 17'd65536;
      cfg_q.noise_cut_enable <= 1'b0;
      cfg_q.noise_cut_factor <= 12'd512;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_AXIS_SELECT:      cfg_q.axis_select      <= cfg_i.data[0];
        REG_NUM_STRIPS:       cfg_q.num_strips       <= cfg_i.data[NUM_W-1:0];
        REG_INV_STRIP_WIDTH:  cfg_q.inv_strip_width  <= cfg_i.data[INV_W-1:0];
        REG_CENTER_ETA:       cfg_q.center_eta       <= cfg_i.data[ETA_W-1:0];
        REG_CENTER_PHI:       cfg_q.center_phi       <= cfg_i.data[PHI_W-1:0];
        REG_ENERGY_SCALE:     cfg_q.energy_scale     <= cfg_i.data[SCALE_W-1:0];
        REG_NOISE_CUT_ENABLE: cfg_q.noise_cut_enable <= cfg_i.data[0];
        REG_NOISE_CUT_FACTOR: cfg_q.noise_cut_factor <= cfg_i.data[FACT_W-1:0];
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // strip count in use: zero acts as one, large values clamp
  always_comb begin
    priority if (cfg_q.num_strips == '0) begin
      n_eff = NUM_W'(1);
    end else if (cfg_q.num_strips > NUM_W'(MAX_STRIPS)) begin
      n_eff = NUM_W'(MAX_STRIPS);
    end else begin
      n_eff = cfg_q.num_strips;
    end
  end

  assign cell_i.ready = (state_q == ST_IDLE);
  assign accept       = cell_i.valid && cell_i.ready;

  cseb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .cell_eta_i    (cell_i.cell_eta),
    .cell_phi_i    (cell_i.cell_phi),
    .cell_energy_i (cell_i.cell_energy),
    .cell_sigma_i  (cell_i.cell_sigma),
    .cell_valid_i  (cell_i.cell_valid),
    .last_cell_i   (cell_i.last_cell),
    .cfg_i         (cfg_q),
    .n_eff_i       (n_eff),
    .bin_o         (bin),
    .addend_o      (addend)
  );

  // cell row, strip 0 at the head
  for (genvar k = 0; k < MAX_STRIPS; k++) begin : g_cell
    logic signed [SUM_W-1:0] next_sum;

    if (k == MAX_STRIPS - 1) begin : g_tail
      assign next_sum = '0;
    end else begin : g_mid
      // the last word out leaves the whole row cleared
      assign next_sum = last_out ? '0 : sums[k+1];
    end

    assign ctrl[k].hit   = bin.valid && bin.hit && (bin.strip == STRIP_W'(k));
    assign ctrl[k].shift = out_take;

    cseb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[k]),
      .addend_i (addend),
      .shift_i  (next_sum),
      .sum_o    (sums[k])
    );
  end

  assign last_out = ({{(NUM_W-CNT_W){1'b0}}, cnt_q} == (n_eff - NUM_W'(1)));
  assign out_take = strip_o.valid && strip_o.ready;

  assign strip_o.valid       = (state_q == ST_READ);
  assign strip_o.strip_index = STRIP_W'(cnt_q);
  assign strip_o.strip_sum   = sums[0];
  assign strip_o.last_strip  = last_out;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (bin.valid) begin
          state_d = bin.last ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_take) begin
          if (last_out) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: bench/calorimeter_strip_energy_binner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calorimeter_strip_energy_binner_tb
// Drives cell words and register writes into the strip energy binner and
// checks every strip word it reads out against a predictor of the binning.
// Directed cases for rounding, wrap, clamping, noise cut, strip count and
// saturation come first, then random clusters under random settings.
// ----------------------------------------------------------------------------
module calorimeter_strip_energy_binner_tb;
  import cseb_pkg::*;

  localparam int unsigned MAX_STRIPS   = 64;
  localparam int          RANDOM_ITEMS = 100;
  localparam int          DRAIN_CYC    = 16;
  localparam longint      SUM_MAX      = (64'sd1 <<< 47) - 1;
  localparam longint      SUM_MIN      = -(64'sd1 <<< 47);
  localparam longint      PHI_PI       = 12868;
  localparam longint      PHI_2PI      = 25736;

  typedef struct {
    logic signed [ETA_W-1:0] cell_eta;
    logic signed [PHI_W-1:0] cell_phi;
    logic signed [EN_W-1:0]  cell_energy;
    logic [SIG_W-1:0]        cell_sigma;
    logic                    cell_valid;
    logic                    last_cell;
  } cell_word_t;

  typedef struct {
    logic [STRIP_W-1:0]      strip_nr;
    logic signed [SUM_W-1:0] sum;
    logic                    is_last;
  } strip_word_t;

  logic clk_i;
  logic rst_ni;

  cseb_cfg_if   cfg_bus ();
  cseb_cell_if  cell_bus ();
  cseb_strip_if strip_bus ();

  calorimeter_strip_energy_binner #(
    .MAX_STRIPS(MAX_STRIPS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .cell_i (cell_bus),
    .strip_o(strip_bus)
  );

  cseb_cfg_t   cfg_shadow;
  longint      strip_acc [MAX_STRIPS];
  strip_word_t strips_due[$];
  int          errors;
  bit          src_gap_en;
  bit          sink_stall_en;
  int          stall_left;
  strip_word_t want;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // predictor: bin one accepted cell, queue the readout on the last one
  function automatic void bin_cell(cell_word_t c);
    longint n, dphi, d, ridx, strip, s;
    bit keep;
    strip_word_t w;
    n = cfg_shadow.num_strips;
    if (n < 1) n = 1;
    if (n > MAX_STRIPS) n = MAX_STRIPS;
    keep = c.cell_valid;
    if (cfg_shadow.noise_cut_enable &&
        longint'(c.cell_energy) * 256 <=
        longint'(cfg_shadow.noise_cut_factor) * longint'(c.cell_sigma))
      keep = 1'b0;
    if (keep) begin
      dphi = longint'(cfg_shadow.center_phi) - longint'(c.cell_phi);
      if (dphi < -PHI_PI) dphi += PHI_2PI;
      else if (dphi >= PHI_PI) dphi -= PHI_2PI;
      d = cfg_shadow.axis_select ? dphi
                                 : longint'(cfg_shadow.center_eta) - longint'(c.cell_eta);
      ridx = (d * longint'(cfg_shadow.inv_strip_width) + (64'sd1 <<< 19)) >>> 20;
      strip = n / 2 - 2 * ridx - ((dphi > 0) ? 1 : 0);
      if (strip < 0) strip = 0;
      if (strip < n) begin
        s = strip_acc[strip] +
            longint'(c.cell_energy) * longint'(cfg_shadow.energy_scale);
        if (s > SUM_MAX) s = SUM_MAX;
        if (s < SUM_MIN) s = SUM_MIN;
        strip_acc[strip] = s;
      end
    end
    if (c.last_cell) begin
      for (longint k = 0; k < n; k++) begin
        w.strip_nr = k[STRIP_W-1:0];
        w.sum      = strip_acc[k][SUM_W-1:0];
        w.is_last  = (k == n - 1);
        strips_due.insert(strips_due.size(), w);
      end
      for (int k = 0; k < MAX_STRIPS; k++) strip_acc[k] = 0;
    end
  endfunction

  function automatic cell_word_t mk_cell(longint eta, longint phi, longint energy,
                                         longint sigma, bit cv, bit last);
    cell_word_t c;
    c.cell_eta    = eta[ETA_W-1:0];
    c.cell_phi    = phi[PHI_W-1:0];
    c.cell_energy = energy[EN_W-1:0];
    c.cell_sigma  = sigma[SIG_W-1:0];
    c.cell_valid  = cv;
    c.last_cell   = last;
    return c;
  endfunction

  task automatic send_cell(cell_word_t c);
    int gap;
    gap = src_gap_en ? (($urandom_range(0, 9) < 6) ? 0 : pick_gap()) : 0;
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_bus.valid       <= 1'b1;
    cell_bus.cell_eta    <= c.cell_eta;
    cell_bus.cell_phi    <= c.cell_phi;
    cell_bus.cell_energy <= c.cell_energy;
    cell_bus.cell_sigma  <= c.cell_sigma;
    cell_bus.cell_valid  <= c.cell_valid;
    cell_bus.last_cell   <= c.last_cell;
    do @(posedge clk_i); while (!cell_bus.ready);
    bin_cell(c);
  endtask

  task automatic hold_until_drained();
    cell_bus.valid <= 1'b0;
    while (strips_due.size() != 0) @(posedge clk_i);
  endtask

  // cells without a readout may still be in the front pipe
  task automatic wait_idle();
    hold_until_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] ri, longint value);
    logic [CFG_DATA_W-1:0] d;
    d = value[CFG_DATA_W-1:0];
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= ri;
    cfg_bus.data  <= d;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (ri)
      REG_AXIS_SELECT:      cfg_shadow.axis_select      = d[0];
      REG_NUM_STRIPS:       cfg_shadow.num_strips       = d[NUM_W-1:0];
      REG_INV_STRIP_WIDTH:  cfg_shadow.inv_strip_width  = d[INV_W-1:0];
      REG_CENTER_ETA:       cfg_shadow.center_eta       = d[ETA_W-1:0];
      REG_CENTER_PHI:       cfg_shadow.center_phi       = d[PHI_W-1:0];
      REG_ENERGY_SCALE:     cfg_shadow.energy_scale     = d[SCALE_W-1:0];
      REG_NOISE_CUT_ENABLE: cfg_shadow.noise_cut_enable = d[0];
      default:              cfg_shadow.noise_cut_factor = d[FACT_W-1:0];
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random cell, mostly placed near the centre so that it lands in a strip
  function automatic cell_word_t random_cell(bit last);
    longint n, span, d, eta, phi, energy, sigma;
    bit cv;
    if ($urandom_range(0, 99) < 12) begin
      return mk_cell(longint'($urandom_range(0, 40959)) - 20480,
                     longint'($urandom_range(0, 25736)) - 12868,
                     longint'($urandom), longint'($urandom),
                     $urandom_range(0, 1), last);
    end
    n = cfg_shadow.num_strips;
    if (n < 1) n = 1;
    if (n > MAX_STRIPS) n = MAX_STRIPS;
    span = ((n / 4 + 2) <<< 20) / ((cfg_shadow.inv_strip_width == 0) ? 1 :
                                   longint'(cfg_shadow.inv_strip_width));
    if (span > 12000) span = 12000;
    d = $urandom_range(0, 2 * span);
    d = d - span;
    eta = longint'(cfg_shadow.center_eta) - (cfg_shadow.axis_select ? 0 : d);
    if (eta < -20480) eta = -20480;
    if (eta > 20479) eta = 20479;
    phi = longint'(cfg_shadow.center_phi) -
          (cfg_shadow.axis_select ? d : longint'($urandom_range(0, 400)) - 200);
    if (phi < -PHI_PI) phi += PHI_2PI;
    else if (phi > PHI_PI) phi -= PHI_2PI;
    case ($urandom_range(0, 3))
      0:       energy = longint'($urandom_range(0, 4000)) - 2000;
      1:       energy = $urandom_range(0, 1) ? 8388607 : -8388608;
      default: energy = $urandom;
    endcase
    sigma = cfg_shadow.noise_cut_enable ? longint'($urandom_range(0, 3000))
                                        : longint'($urandom);
    cv = ($urandom_range(0, 9) != 0);
    return mk_cell(eta, phi, energy, sigma, cv, last);
  endfunction

  task automatic write_random_cfg();
    longint v;
    cfg_write(REG_AXIS_SELECT, $urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: v = 1;
      1: v = 2;
      2: v = 63;
      3: v = 64;
      default: v = $urandom_range(1, 64);
    endcase
    cfg_write(REG_NUM_STRIPS, v);
    case ($urandom_range(0, 5))
      0: v = 1;
      1: v = 65535;
      default: v = $urandom_range(256, 16384);
    endcase
    cfg_write(REG_INV_STRIP_WIDTH, v);
    case ($urandom_range(0, 4))
      0: v = -20480;
      1: v = 20479;
      default: v = longint'($urandom_range(0, 40959)) - 20480;
    endcase
    cfg_write(REG_CENTER_ETA, v);
    case ($urandom_range(0, 4))
      0: v = -12868;
      1: v = 12868;
      default: v = longint'($urandom_range(0, 25736)) - 12868;
    endcase
    cfg_write(REG_CENTER_PHI, v);
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 65536;
      default: v = $urandom_range(0, 65536);
    endcase
    cfg_write(REG_ENERGY_SCALE, v);
    cfg_write(REG_NOISE_CUT_ENABLE, ($urandom_range(0, 3) == 0));
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = 4095;
      default: v = $urandom_range(0, 4095);
    endcase
    cfg_write(REG_NOISE_CUT_FACTOR, v);
  endtask

  // reset settings, field extremes, clamp to strip 0, drop past the count
  task automatic test_reset_defaults();
    send_cell(mk_cell(0, 0, 1000, 5, 1, 0));
    send_cell(mk_cell(0, 0, 8388607, 0, 0, 0));
    send_cell(mk_cell(20479, 0, 777, 8388607, 1, 0));
    send_cell(mk_cell(-20480, 0, 8388607, 0, 1, 0));
    send_cell(mk_cell(0, -12868, -8388608, 0, 1, 0));
    send_cell(mk_cell(0, 12868, 4242, 0, 1, 0));
    send_cell(mk_cell(0, -1, -55, 0, 1, 0));
    send_cell(mk_cell(0, 0, 99, 0, 0, 1));
  endtask

  // rounding half up on both sides of zero
  task automatic test_rounding();
    wait_idle();
    cfg_write(REG_INV_STRIP_WIDTH, 256);
    send_cell(mk_cell(-2048, 0, 11, 0, 1, 0));
    send_cell(mk_cell(-2047, 0, 22, 0, 1, 0));
    send_cell(mk_cell(2048, 0, 33, 0, 1, 0));
    send_cell(mk_cell(2049, 0, 44, 0, 1, 0));
    wait_idle();
    cfg_write(REG_CENTER_ETA, 20479);
    send_cell(mk_cell(-20480, 0, 55, 0, 1, 1));
  endtask

  // cut at exactly factor times sigma, factor extremes
  task automatic test_noise_cut();
    wait_idle();
    cfg_write(REG_CENTER_ETA, 0);
    cfg_write(REG_NOISE_CUT_ENABLE, 1);
    send_cell(mk_cell(0, 0, 200, 100, 1, 0));
    send_cell(mk_cell(0, 0, 201, 100, 1, 0));
    send_cell(mk_cell(0, 0, 0, 0, 1, 0));
    send_cell(mk_cell(0, 0, -8388608, 0, 1, 0));
    send_cell(mk_cell(0, 0, 8388607, 8388607, 1, 0));
    wait_idle();
    cfg_write(REG_NOISE_CUT_FACTOR, 0);
    send_cell(mk_cell(0, 0, 1, 8388607, 1, 0));
    wait_idle();
    cfg_write(REG_NOISE_CUT_FACTOR, 4095);
    send_cell(mk_cell(0, 0, 8388607, 8388607, 1, 1));
  endtask

  // phi axis, wrap at both ends, positive offset steps one strip down
  task automatic test_phi_axis();
    wait_idle();
    cfg_write(REG_NOISE_CUT_ENABLE, 0);
    cfg_write(REG_AXIS_SELECT, 1);
    cfg_write(REG_CENTER_PHI, 12868);
    cfg_write(REG_CENTER_ETA, -20480);
    cfg_write(REG_INV_STRIP_WIDTH, 65535);
    cfg_write(REG_ENERGY_SCALE, 12345);
    send_cell(mk_cell(0, -12868, 300, 0, 1, 0));
    send_cell(mk_cell(20479, 12868, 400, 0, 1, 0));
    send_cell(mk_cell(0, 12000, 500, 0, 1, 0));
    send_cell(mk_cell(0, 12867, 600, 0, 1, 0));
    wait_idle();
    cfg_write(REG_CENTER_PHI, -12868);
    send_cell(mk_cell(0, 12868, 700, 0, 1, 1));
  endtask

  // strip count outside the range, changed with sums still held
  task automatic test_strip_count();
    wait_idle();
    cfg_write(REG_AXIS_SELECT, 0);
    cfg_write(REG_ENERGY_SCALE, 0);
    send_cell(mk_cell(0, 0, 8388607, 0, 1, 0));
    wait_idle();
    cfg_write(REG_ENERGY_SCALE, 65536);
    cfg_write(REG_INV_STRIP_WIDTH, 10240);
    cfg_write(REG_CENTER_ETA, 0);
    cfg_write(REG_CENTER_PHI, 0);
    send_cell(mk_cell(0, 0, 123, 0, 1, 0));
    wait_idle();
    cfg_write(REG_NUM_STRIPS, 0);
    send_cell(mk_cell(0, 0, 321, 0, 1, 1));
    wait_idle();
    cfg_write(REG_NUM_STRIPS, 127);
    send_cell(mk_cell(0, 0, 0, 0, 0, 1));
  endtask

  // drive one strip past the top, then step it back down from the clamp
  task automatic test_saturation();
    wait_idle();
    cfg_write(REG_NUM_STRIPS, 64);
    src_gap_en    = 1'b0;
    sink_stall_en = 1'b0;
    for (int k = 0; k < 257; k++) begin
      send_cell(mk_cell(0, 0, 8388607, 0, 1, 0));
    end
    send_cell(mk_cell(0, 0, -8388608, 0, 1, 0));
    send_cell(mk_cell(-100, 0, -8388608, 0, 1, 1));
    src_gap_en    = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  task automatic test_random_clusters();
    int sent, clusters, len;
    cell_word_t c;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      write_random_cfg();
      src_gap_en    = ($urandom_range(0, 3) != 0);
      sink_stall_en = ($urandom_range(0, 3) != 0);
      clusters = $urandom_range(2, 5);
      for (int q = 0; q < clusters; q++) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          c = random_cell(k == len - 1);
          send_cell(c);
          if (c.cell_valid || c.last_cell) sent++;
        end
        if ($urandom_range(0, 5) == 0) hold_until_drained();
      end
    end
    src_gap_en    = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  // strip side: random back-pressure
  always @(posedge clk_i) begin
    if (!sink_stall_en) begin
      strip_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      strip_bus.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      strip_bus.ready <= 1'b0;
      stall_left      <= pick_gap() - 1;
    end else begin
      strip_bus.ready <= 1'b1;
    end
  end

  // compare each strip word with the oldest one due
  always @(posedge clk_i) begin
    if (rst_ni && strip_bus.valid && strip_bus.ready) begin
      if (strips_due.size() == 0) begin
        errors++;
        $display("%0t unexpected strip word: expected none, actual strip %0d sum %0d",
                 $time, strip_bus.strip_index, strip_bus.strip_sum);
      end else begin
        want = strips_due.pop_front();
        if (strip_bus.strip_index !== want.strip_nr) begin
          errors++;
          $display("%0t strip_index mismatch: expected %0d, actual %0d",
                   $time, want.strip_nr, strip_bus.strip_index);
        end
        if (strip_bus.strip_sum !== want.sum) begin
          errors++;
          $display("%0t strip_sum mismatch (strip %0d): expected %0d, actual %0d",
                   $time, want.strip_nr, want.sum, strip_bus.strip_sum);
        end
        if (strip_bus.last_strip !== want.is_last) begin
          errors++;
          $display("%0t last_strip mismatch (strip %0d): expected %0b, actual %0b",
                   $time, want.strip_nr, want.is_last, strip_bus.last_strip);
        end
      end
    end
  end

  initial begin
    errors               = 0;
    src_gap_en           = 1'b1;
    sink_stall_en        = 1'b1;
    stall_left           = 0;
    rst_ni               = 1'b0;
    cell_bus.valid       = 1'b0;
    cell_bus.cell_eta    = '0;
    cell_bus.cell_phi    = '0;
    cell_bus.cell_energy = '0;
    cell_bus.cell_sigma  = '0;
    cell_bus.cell_valid  = 1'b0;
    cell_bus.last_cell   = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    strip_bus.ready      = 1'b0;
    cfg_shadow.axis_select      = 1'b0;
    cfg_shadow.num_strips       = 7'd64;
    cfg_shadow.inv_strip_width  = 16'd10240;
    cfg_shadow.center_eta       = '0;
    cfg_shadow.center_phi       = '0;
    cfg_shadow.energy_scale     = 17'd65536;
    cfg_shadow.noise_cut_enable = 1'b0;
    cfg_shadow.noise_cut_factor = 12'd512;
    for (int k = 0; k < MAX_STRIPS; k++) strip_acc[k] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_rounding();
    test_noise_cut();
    test_phi_axis();
    test_strip_count();
    test_saturation();
    test_random_clusters();
    wait_idle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
